// File: rtl/tnps_pkg.sv
// Package for the trajectory nearest point search block.
// Holds request kind codes, result status codes and fixed field widths.
// No dependencies.
`default_nettype none

package tnps_pkg;

   // Request kind, carried in the input tuser.
   localparam int REQ_KIND_BITS = 2;
   typedef logic [REQ_KIND_BITS-1:0] req_kind_type;

   localparam req_kind_type REQ_APPEND = 2'd0;
   localparam req_kind_type REQ_QUERY  = 2'd1;
   localparam req_kind_type REQ_CLEAR  = 2'd2;

   // Result status, carried in the result tuser.
   typedef logic status_type;

   localparam status_type STATUS_FOUND = 1'b0;
   localparam status_type STATUS_EMPTY = 1'b1;

   // The reported index is always this wide, whatever the table depth.
   localparam int INDEX_BITS = 6;

endpackage

`default_nettype wire

// File: rtl/tnps_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Used for the trajectory point table. No dependencies.
`default_nettype none

module tnps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/trajectory_nearest_point_search_top.sv
// Trajectory nearest point search. Append, clear and unknown request transfers give no result.
// A query first runs S bisection steps through S_MID_RD, S_MID_MUL and S_MID_SUM (at most
// ceil(log2(count-1)), 6 for a full 64-point table, none for one or two points), then reads
// and scores both neighbors and waits in S_EMIT while an earlier result still waits in the
// output register; an empty table goes straight to S_EMIT. Requests are taken only while idle.
// Reset (synchronous, active high) empties the table and idles the controller; the RAM is kept.
`default_nettype none

module trajectory_nearest_point_search_top #(
   parameter int MAX_POINTS = 64,
   parameter int POS_BITS   = 24,
   parameter int MOM_BITS   = 18
) (
   input  wire  clock,
   input  wire  reset,

   // Request channel.
   input  wire  req_tvalid,
   output logic req_tready,
   // tdata, lowest bit first: pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, zero fill.
   input  wire  [(((3*POS_BITS + 3*MOM_BITS) + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: req_type.
   input  wire  [tnps_pkg::REQ_KIND_BITS-1:0] req_tuser,

   // Result channel.
   output logic rsp_tvalid,
   input  wire  rsp_tready,
   // tdata, lowest bit first: nearest_index, nearest_pos_x, nearest_pos_y, nearest_pos_z,
   // nearest_mom_x, nearest_mom_y, nearest_mom_z, zero fill.
   output logic [((tnps_pkg::INDEX_BITS + 3*POS_BITS + 3*MOM_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // tuser: status.
   output logic rsp_tuser
);

   localparam int ENTRY_W  = 3*POS_BITS + 3*MOM_BITS;
   localparam int OUT_W    = ((tnps_pkg::INDEX_BITS + ENTRY_W + 7) / 8) * 8;
   localparam int IDX_BITS = $clog2(MAX_POINTS);
   localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
   // The three multipliers serve both the dot product and the squared distance.
   localparam int MUL_W    = (POS_BITS + 1 > MOM_BITS) ? POS_BITS + 1 : MOM_BITS;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int SUM_W    = PROD_W + 2;

   // Controller states.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MID_RD  = 4'd1;
   localparam logic [3:0] S_MID_MUL = 4'd2;
   localparam logic [3:0] S_MID_SUM = 4'd3;
   localparam logic [3:0] S_LO_RD   = 4'd4;
   localparam logic [3:0] S_LO_MUL  = 4'd5;
   localparam logic [3:0] S_LO_SUM  = 4'd6;
   localparam logic [3:0] S_HI_RD   = 4'd7;
   localparam logic [3:0] S_HI_MUL  = 4'd8;
   localparam logic [3:0] S_HI_SUM  = 4'd9;
   localparam logic [3:0] S_EMIT    = 4'd10;

   // Control registers.
   logic [3:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // Payload registers.
   logic [IDX_BITS-1:0]      lo_ff, lo_in;
   logic [IDX_BITS-1:0]      hi_ff, hi_in;
   logic [3*POS_BITS-1:0]    query_ff, query_in;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [SUM_W-1:0]  dist_lo_ff, dist_lo_in;
   logic [ENTRY_W-1:0]       lo_entry_ff, lo_entry_in;
   logic [ENTRY_W-1:0]       hi_entry_ff, hi_entry_in;
   logic                     empty_ff, empty_in;
   logic                     pick_hi_ff, pick_hi_in;
   logic [OUT_W-1:0]         rsp_tdata_ff, rsp_tdata_in;
   logic                     rsp_tuser_ff, rsp_tuser_in;

   // Point table access.
   logic                ram_wr_en;
   logic [IDX_BITS-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   // Datapath.
   logic                     req_fire;
   logic [IDX_BITS:0]        mid_sum;
   logic [IDX_BITS-1:0]      mid;
   logic [IDX_BITS-1:0]      span;
   logic [IDX_BITS-1:0]      count_last;
   logic signed [POS_BITS:0] diff [3];
   logic signed [MUL_W-1:0]  op_a [3];
   logic signed [MUL_W-1:0]  op_b [3];
   logic signed [SUM_W-1:0]  prod_sum;
   logic                     dot_positive;
   logic                     out_free;
   logic [IDX_BITS-1:0]      pick_idx;
   logic [IDX_BITS+tnps_pkg::INDEX_BITS-1:0] pick_idx_ext;

   // The point table holds one whole point per entry, laid out like the request tdata.
   // Appends write only while idle and queries use the read data only while busy, so a query
   // never uses an entry that is written in the same cycle.
   tnps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (req_tdata[ENTRY_W-1:0]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign ram_wr_en  = req_fire && (req_tuser == tnps_pkg::REQ_APPEND)
                       && (count_ff < CNT_BITS'(MAX_POINTS));

   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[IDX_BITS:1];
   assign count_last = IDX_BITS'(count_ff - 1'b1);

   // The read address is presented in the state before the one that uses the data.
   always_comb begin
      case (state_ff)
         S_LO_RD: ram_rd_addr = lo_ff;
         S_HI_RD: ram_rd_addr = hi_ff;
         default: ram_rd_addr = mid;
      endcase
   end

   // Per axis: query minus stored position, then either times the momentum (bisection step)
   // or times itself (squared distance).
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = $signed({query_ff[k*POS_BITS + POS_BITS - 1],
                            query_ff[k*POS_BITS +: POS_BITS]})
                 - $signed({ram_rd_data[k*POS_BITS + POS_BITS - 1],
                            ram_rd_data[k*POS_BITS +: POS_BITS]});
         op_a[k] = MUL_W'(diff[k]);
         if (state_ff == S_MID_MUL) begin
            op_b[k] = MUL_W'($signed(ram_rd_data[3*POS_BITS + k*MOM_BITS +: MOM_BITS]));
         end else begin
            op_b[k] = MUL_W'(diff[k]);
         end
      end
   end

   assign prod_sum     = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
   assign dot_positive = !prod_sum[SUM_W-1] && (prod_sum != '0);
   assign out_free     = !rsp_tvalid_ff || rsp_tready;
   assign pick_idx     = pick_hi_ff ? hi_ff : lo_ff;
   assign pick_idx_ext = {{tnps_pkg::INDEX_BITS{1'b0}}, pick_idx};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      query_in      = query_ff;
      dist_lo_in    = dist_lo_ff;
      lo_entry_in   = lo_entry_ff;
      hi_entry_in   = hi_entry_ff;
      empty_in      = empty_ff;
      pick_hi_in    = pick_hi_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      span          = IDX_BITS'(hi_ff - lo_ff);
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = prod_ff[k];
      end

      // A waiting result leaves the output register once it is taken.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  tnps_pkg::REQ_APPEND: begin
                     if (ram_wr_en) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  tnps_pkg::REQ_CLEAR: begin
                     count_in = '0;
                  end
                  tnps_pkg::REQ_QUERY: begin
                     query_in = req_tdata[3*POS_BITS-1:0];
                     lo_in    = '0;
                     hi_in    = count_last;
                     empty_in = (count_ff == '0);
                     if (count_ff == '0) begin
                        state_in = S_EMIT;
                     end else if (count_last > IDX_BITS'(1)) begin
                        state_in = S_MID_RD;
                     end else begin
                        state_in = S_LO_RD;
                     end
                  end
                  default: begin
                     // Unknown request kinds are dropped.
                  end
               endcase
            end
         end
         S_MID_RD: state_in = S_MID_MUL;
         S_MID_MUL: begin
            for (int k = 0; k < 3; k++) begin
               prod_in[k] = PROD_W'(op_a[k]) * PROD_W'(op_b[k]);
            end
            state_in = S_MID_SUM;
         end
         S_MID_SUM: begin
            if (dot_positive) begin
               lo_in = mid;
            end else begin
               hi_in = mid;
            end
            span = IDX_BITS'(hi_in - lo_in);
            state_in = (span > IDX_BITS'(1)) ? S_MID_RD : S_LO_RD;
         end
         S_LO_RD: state_in = S_LO_MUL;
         S_LO_MUL: begin
            for (int k = 0; k < 3; k++) begin
               prod_in[k] = PROD_W'(op_a[k]) * PROD_W'(op_b[k]);
            end
            lo_entry_in = ram_rd_data;
            state_in    = S_LO_SUM;
         end
         S_LO_SUM: begin
            dist_lo_in = prod_sum;
            state_in   = S_HI_RD;
         end
         S_HI_RD: state_in = S_HI_MUL;
         S_HI_MUL: begin
            for (int k = 0; k < 3; k++) begin
               prod_in[k] = PROD_W'(op_a[k]) * PROD_W'(op_b[k]);
            end
            hi_entry_in = ram_rd_data;
            state_in    = S_HI_SUM;
         end
         S_HI_SUM: begin
            // The right neighbor wins a tie.
            pick_hi_in = !(dist_lo_ff < prod_sum);
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               if (empty_ff) begin
                  rsp_tuser_in = tnps_pkg::STATUS_EMPTY;
                  rsp_tdata_in = '0;
               end else begin
                  rsp_tuser_in = tnps_pkg::STATUS_FOUND;
                  rsp_tdata_in = OUT_W'({pick_hi_ff ? hi_entry_ff : lo_entry_ff,
                                         pick_idx_ext[tnps_pkg::INDEX_BITS-1:0]});
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      query_ff     <= query_in;
      dist_lo_ff   <= dist_lo_in;
      lo_entry_ff  <= lo_entry_in;
      hi_entry_ff  <= hi_entry_in;
      empty_ff     <= empty_in;
      pick_hi_ff   <= pick_hi_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire
